### rtl/lpd_pkg.sv
// lpd_pkg: shared types and constants of the length prefix deframer
// used by lpd_parse, lpd_out_reg and length_prefix_deframer; no dependencies
`default_nettype none

package lpd_pkg;

   // header phase of the frame parser
   typedef enum logic [1:0] {
      PH_SHORT   = 2'd0,
      PH_LONG    = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   localparam logic [15:0] ESCAPE_LEN      = 16'hFFFF;
   localparam logic [2:0]  SHORT_HDR_BYTES = 3'd2;
   localparam logic [2:0]  LONG_HDR_BYTES  = 3'd4;

   // one result item
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [31:0] frame_length;
      logic        long_header;
      logic        empty_frame;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

### rtl/lpd_parse.sv
// lpd_parse: header gathering, frame length and payload count state
// depends on lpd_pkg for the phase enum, header constants and result struct
`default_nettype none

module lpd_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         data_byte,
   output logic                    res_valid,
   output lpd_pkg::result_type     res
);

   lpd_pkg::phase_type phase_ff, phase_in;
   logic [31:0] header_shift_ff, header_shift_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] remaining_ff, remaining_in;
   logic        long_ff, long_in;

   logic [31:0] shifted;
   logic [2:0]  count_inc;
   logic [31:0] rem_dec;
   logic        rem_last;
   logic        in_short;
   logic        escape_hit;
   logic        short_done;
   logic        long_done;
   logic        frame_start;
   logic [31:0] hdr_len;
   logic        len_zero;

   // header decode shared by next-state and output logic
   always_comb begin
      shifted     = {header_shift_ff[23:0], data_byte};
      count_inc   = header_count_ff + 3'd1;
      rem_dec     = remaining_ff - 32'd1;
      rem_last    = (rem_dec == 32'd0);
      in_short    = (phase_ff != lpd_pkg::PH_LONG) && (phase_ff != lpd_pkg::PH_PAYLOAD);
      escape_hit  = in_short && (count_inc >= lpd_pkg::SHORT_HDR_BYTES)
                    && (shifted[15:0] == lpd_pkg::ESCAPE_LEN);
      short_done  = in_short && (count_inc >= lpd_pkg::SHORT_HDR_BYTES)
                    && (shifted[15:0] != lpd_pkg::ESCAPE_LEN);
      long_done   = (phase_ff == lpd_pkg::PH_LONG) && (count_inc >= lpd_pkg::LONG_HDR_BYTES);
      frame_start = short_done || long_done;
      hdr_len     = long_done ? shifted : {16'd0, shifted[15:0]};
      len_zero    = (hdr_len == 32'd0);
   end

   // next state
   always_comb begin
      phase_in        = phase_ff;
      header_shift_in = header_shift_ff;
      header_count_in = header_count_ff;
      length_in       = length_ff;
      remaining_in    = remaining_ff;
      long_in         = long_ff;
      case (phase_ff)
         lpd_pkg::PH_PAYLOAD: begin
            remaining_in = rem_dec;
            if (rem_last) begin
               phase_in        = lpd_pkg::PH_SHORT;
               header_shift_in = 32'd0;
               header_count_in = 3'd0;
            end
         end
         default: begin
            // short and long header phases; unused code behaves as short
            phase_in        = (phase_ff == lpd_pkg::PH_LONG) ? lpd_pkg::PH_LONG
                                                             : lpd_pkg::PH_SHORT;
            header_shift_in = shifted;
            header_count_in = count_inc;
            if (escape_hit) begin
               phase_in        = lpd_pkg::PH_LONG;
               header_shift_in = 32'd0;
               header_count_in = 3'd0;
            end else if (frame_start) begin
               long_in         = long_done;
               length_in       = hdr_len;
               header_shift_in = 32'd0;
               header_count_in = 3'd0;
               remaining_in    = hdr_len;
               phase_in        = len_zero ? lpd_pkg::PH_SHORT : lpd_pkg::PH_PAYLOAD;
            end
         end
      endcase
   end

   // result of the current byte
   always_comb begin
      res_valid        = 1'b0;
      res.payload_byte = 8'd0;
      res.frame_length = length_ff;
      res.long_header  = long_ff;
      res.empty_frame  = 1'b0;
      res.last         = 1'b0;
      case (phase_ff)
         lpd_pkg::PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.payload_byte = data_byte;
            res.last         = rem_last;
         end
         default: begin
            if (frame_start && len_zero) begin
               res_valid        = 1'b1;
               res.frame_length = hdr_len;
               res.long_header  = long_done;
               res.empty_frame  = 1'b1;
               res.last         = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= lpd_pkg::PH_SHORT;
         header_shift_ff <= 32'd0;
         header_count_ff <= 3'd0;
         length_ff       <= 32'd0;
         remaining_ff    <= 32'd0;
         long_ff         <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         header_shift_ff <= header_shift_in;
         header_count_ff <= header_count_in;
         length_ff       <= length_in;
         remaining_ff    <= remaining_in;
         long_ff         <= long_in;
      end
   end

`ifndef SYNTH
   a_payload_gives_result: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpd_pkg::PH_PAYLOAD) |-> res_valid)
      else $error("payload byte without result");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.empty_frame) |-> (res.last && (res.payload_byte == 8'd0)))
      else $error("empty frame result not marked last");

   a_last_leaves_payload: assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid && res.last) |=> (phase_ff == lpd_pkg::PH_SHORT))
      else $error("frame end did not return to short header");

   a_short_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpd_pkg::PH_SHORT) |-> (header_count_ff < lpd_pkg::SHORT_HDR_BYTES))
      else $error("short header count overflow");
`endif

endmodule

`default_nettype wire

### rtl/lpd_out_reg.sv
// lpd_out_reg: result register that holds one item until the consumer takes it
// depends on lpd_pkg for the result struct
`default_nettype none

module lpd_out_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               res_valid,
   input  wire lpd_pkg::result_type res,
   output logic                    space,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output lpd_pkg::result_type     rsp_data
);

   logic                valid_ff, valid_in;
   lpd_pkg::result_type data_ff;

   // room when empty or the held item leaves this cycle
   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = res_valid;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

### rtl/length_prefix_deframer.sv
// length_prefix_deframer: top level, splits a byte stream into length-prefixed frames
// depends on lpd_pkg, lpd_parse and lpd_out_reg
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_data_byte[7:0]
//   rsp      out  rsp_valid/rsp_ready    rsp_payload_byte, rsp_frame_length,
//                                        rsp_long_header, rsp_empty_frame, rsp_last
//
// one byte per cycle unless rsp back-pressure stalls req; a result appears on rsp in the cycle after its byte is taken
// header bytes give no result; a zero-length frame gives one empty item
// the parse state and the result register are the only storage
// reset is synchronous and leaves the parser waiting for a short header
// req_ready drops only while a result is held and rsp_ready is low
`default_nettype none

module length_prefix_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_payload_byte,
   output logic [31:0]      rsp_frame_length,
   output logic             rsp_long_header,
   output logic             rsp_empty_frame,
   output logic             rsp_last
);

   logic                accept;
   logic                space;
   logic                res_valid;
   lpd_pkg::result_type res;
   lpd_pkg::result_type rsp_data;

   assign req_ready = space;
   assign accept    = req_valid && space;

   lpd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   lpd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .res_valid (res_valid),
      .res       (res),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_frame_length = rsp_data.frame_length;
   assign rsp_long_header  = rsp_data.long_header;
   assign rsp_empty_frame  = rsp_data.empty_frame;
   assign rsp_last         = rsp_data.last;

endmodule

`default_nettype wire

### verif/length_prefix_deframer_test.sv
// length_prefix_deframer_test: self-checking bench for the length prefix deframer
// drives framed byte streams under varied idling and back-pressure, checks every result item
// depends on lpd_pkg and length_prefix_deframer
`default_nettype none

module length_prefix_deframer_test;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PHASE_BYTES    = 300;
   localparam int MAX_REPORTS    = 10;
   localparam int BUF_BITS       = 12;
   localparam int BUF_DEPTH      = 1 << BUF_BITS;
   localparam logic [15:0] ESC_WORD = lpd_pkg::ESCAPE_LEN;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic [31:0] rsp_frame_length;
   logic        rsp_long_header;
   logic        rsp_empty_frame;
   logic        rsp_last;

   length_prefix_deframer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_long_header  (rsp_long_header),
      .rsp_empty_frame  (rsp_empty_frame),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pending stream bytes and predicted result items
   logic [7:0]          byte_buf [0:BUF_DEPTH-1];
   lpd_pkg::result_type exp_buf  [0:BUF_DEPTH-1];
   int byte_wr = 0;
   int byte_rd = 0;
   int exp_wr  = 0;
   int exp_rd  = 0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_started = 0;
   int hold_left     = 0;

   int bytes_pushed  = 0;
   int bytes_taken   = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int frames_short  = 0;
   int frames_long   = 0;
   int frames_empty  = 0;
   int idle_cycles   = 0;

   // deframer state as predicted
   lpd_pkg::phase_type parse_phase = lpd_pkg::PH_SHORT;
   logic [31:0] hdr_shift   = '0;
   logic [2:0]  hdr_count   = '0;
   logic [31:0] frame_len   = '0;
   logic [31:0] bytes_left  = '0;
   logic        long_mode   = 1'b0;

   function void add_expected(input lpd_pkg::result_type r);
      exp_buf[exp_wr[BUF_BITS-1:0]] = r;
      exp_wr++;
   endfunction

   function void start_payload(input logic [31:0] len);
      lpd_pkg::result_type r;
      frame_len = len;
      hdr_shift = '0;
      hdr_count = '0;
      if (len == 32'd0) begin
         parse_phase = lpd_pkg::PH_SHORT;
         bytes_left  = '0;
         r.payload_byte = 8'h00;
         r.frame_length = frame_len;
         r.long_header  = long_mode;
         r.empty_frame  = 1'b1;
         r.last         = 1'b1;
         add_expected(r);
      end else begin
         bytes_left  = len;
         parse_phase = lpd_pkg::PH_PAYLOAD;
      end
   endfunction

   function void deframe_byte(input logic [7:0] b);
      lpd_pkg::result_type r;
      logic [15:0]         short_len;
      if (parse_phase == lpd_pkg::PH_PAYLOAD) begin
         bytes_left = bytes_left - 32'd1;
         r.payload_byte = b;
         r.frame_length = frame_len;
         r.long_header  = long_mode;
         r.empty_frame  = 1'b0;
         r.last         = (bytes_left == 32'd0);
         add_expected(r);
         if (r.last) begin
            parse_phase = lpd_pkg::PH_SHORT;
            hdr_shift   = '0;
            hdr_count   = '0;
         end
      end else begin
         hdr_shift = {hdr_shift[23:0], b};
         hdr_count = hdr_count + 3'd1;
         if (parse_phase == lpd_pkg::PH_LONG) begin
            if (hdr_count >= lpd_pkg::LONG_HDR_BYTES) begin
               long_mode = 1'b1;
               start_payload(hdr_shift);
            end
         end else begin
            parse_phase = lpd_pkg::PH_SHORT;
            if (hdr_count >= lpd_pkg::SHORT_HDR_BYTES) begin
               short_len = hdr_shift[15:0];
               // escape value switches to the 4-byte header
               if (short_len == lpd_pkg::ESCAPE_LEN) begin
                  parse_phase = lpd_pkg::PH_LONG;
                  hdr_shift   = '0;
                  hdr_count   = '0;
               end else begin
                  long_mode = 1'b0;
                  start_payload({16'h0000, short_len});
               end
            end
         end
      end
   endfunction

   task automatic push_byte(input logic [7:0] b);
      byte_buf[byte_wr[BUF_BITS-1:0]] = b;
      byte_wr++;
      bytes_pushed++;
   endtask

   // header, then payload bytes biased toward the byte extremes
   task automatic push_frame(input logic [31:0] len, input bit long_hdr,
                             input int payload_count);
      int k;
      if (long_hdr) begin
         push_byte(ESC_WORD[15:8]);
         push_byte(ESC_WORD[7:0]);
         push_byte(len[31:24]);
         push_byte(len[23:16]);
         frames_long++;
      end else begin
         frames_short++;
      end
      push_byte(len[15:8]);
      push_byte(len[7:0]);
      if (len == 32'd0)
         frames_empty++;
      for (k = 0; k < payload_count; k++) begin
         case ($urandom_range(9))
            0: push_byte(8'h00);
            1: push_byte(8'hFF);
            default: push_byte(8'($urandom_range(255)));
         endcase
      end
   endtask

   task automatic push_random_frames(input int byte_budget);
      int          start;
      int          pick;
      logic [31:0] len;
      start = bytes_pushed;
      while (bytes_pushed - start < byte_budget) begin
         pick = $urandom_range(99);
         if (pick < 10)
            len = 32'd0;
         else if (pick < 70)
            len = 32'($urandom_range(8, 1));
         else if (pick < 92)
            len = 32'($urandom_range(40, 9));
         else
            len = 32'($urandom_range(300, 41));
         push_frame(len, ($urandom_range(3) == 0), int'(len));
      end
   endtask

   task automatic wait_drained;
      @(negedge clock);
      while (!(bytes_taken == bytes_pushed && exp_rd == exp_wr))
         @(negedge clock);
   endtask

   task automatic note_mismatch(input string what, input lpd_pkg::result_type exp_r,
                                input lpd_pkg::result_type act_r);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch (%s) at result %0d: exp %02h %08h %b%b%b got %02h %08h %b%b%b",
                  what, results_seen, exp_r.payload_byte, exp_r.frame_length,
                  exp_r.long_header, exp_r.empty_frame, exp_r.last,
                  act_r.payload_byte, act_r.frame_length, act_r.long_header,
                  act_r.empty_frame, act_r.last);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            deframe_byte(req_data_byte);
            bytes_taken++;
         end
         if (!req_valid || req_ready) begin
            if (byte_rd != byte_wr && $urandom_range(99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_data_byte <= byte_buf[byte_rd[BUF_BITS-1:0]];
               byte_rd++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      lpd_pkg::result_type act_r;
      lpd_pkg::result_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            act_r.payload_byte = rsp_payload_byte;
            act_r.frame_length = rsp_frame_length;
            act_r.long_header  = rsp_long_header;
            act_r.empty_frame  = rsp_empty_frame;
            act_r.last         = rsp_last;
            if (exp_rd == exp_wr) begin
               note_mismatch("unexpected item", '0, act_r);
            end else begin
               exp_r = exp_buf[exp_rd[BUF_BITS-1:0]];
               exp_rd++;
               if (act_r.payload_byte !== exp_r.payload_byte ||
                   act_r.frame_length !== exp_r.frame_length ||
                   act_r.long_header  !== exp_r.long_header  ||
                   act_r.empty_frame  !== exp_r.empty_frame  ||
                   act_r.last         !== exp_r.last)
                  note_mismatch("field", exp_r, act_r);
            end
            results_seen++;
         end
         if (hold_requests != holds_started) begin
            holds_started = hold_requests;
            hold_left     = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 19;
      recv_idle_pct = 77;
      push_frame(32'd0, 1'b0, 0);
      push_frame(32'd1, 1'b0, 1);
      push_frame(32'd3, 1'b0, 3);
      // zero long length gives an empty item with the long mark
      push_frame(32'd0, 1'b1, 0);
      push_frame(32'd2, 1'b1, 2);
      push_random_frames(PHASE_BYTES);
      wait_drained();

      send_idle_pct = 77;
      recv_idle_pct = 19;
      push_random_frames(PHASE_BYTES);
      wait_drained();

      // no idling, with one long receiver hold so the input stalls
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_random_frames(PHASE_BYTES);
      hold_requests++;
      // full 32-bit length stays unsigned; its payload never completes
      push_frame(32'hFFFF_FFFF, 1'b1, 6);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (exp_wr != exp_rd) begin
         $display("%0d expected items never arrived", exp_wr - exp_rd);
         mismatches += exp_wr - exp_rd;
      end
      $display("covered %0d stream bytes and %0d result items over three idle profiles",
               bytes_taken, results_seen);
      $display("frames: %0d short-header, %0d long-header, %0d empty; %0d mismatches",
               frames_short, frames_long, frames_empty, mismatches);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
